[design/swm_pkg.sv]
// swm_pkg: shared constants and types for the sliding window maximum block
// no dependencies; imported by the interfaces, cells, head select and top level
`default_nettype none

package swm_pkg;

	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd3;
	localparam int GROUP = 8;

	typedef struct packed {
		logic advance;
		logic restart;
	} swm_ctrl_t;

endpackage

`default_nettype wire

[design/swm_if.sv]
// swm_if: valid/ready channels of the sliding window maximum block
// depends on swm_pkg for the configuration width
`default_nettype none

interface swm_sample_if #(parameter int SAMPLE_BITS = 16);
	logic valid;
	logic ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic restart;
	modport source (output valid, sample, restart, input ready);
	modport sink (input valid, sample, restart, output ready);
endinterface

interface swm_result_if #(parameter int SAMPLE_BITS = 16);
	logic valid;
	logic ready;
	logic signed [SAMPLE_BITS-1:0] window_max;
	modport source (output valid, window_max, input ready);
	modport sink (input valid, window_max, output ready);
endinterface

interface swm_cfg_if;
	logic valid;
	logic ready;
	logic [swm_pkg::CFG_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

[design/swm_cell.sv]
// swm_cell: one window position; holds the sample that arrived POS requests ago
// depends on swm_pkg; its neighbor toward the newest sample feeds it
`default_nettype none

module swm_cell #(
	parameter int W    = 16,
	parameter int WS_W = 7,
	parameter int POS  = 0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire swm_pkg::swm_ctrl_t    ctrl,
	input  wire logic signed [W-1:0]   sample,
	input  wire logic [WS_W-1:0]       ws,
	input  wire logic signed [W-1:0]   prev_value,
	input  wire logic                  prev_valid,
	output logic signed [W-1:0]        value_q,
	output logic                       valid_q
);
	import swm_pkg::*;

	localparam logic [WS_W-1:0] POS_W = WS_W'(POS);

	logic keep;

	always_comb begin
		if (POS == 0) begin
			keep = 1'b1;
		end else begin
			keep = prev_valid && !ctrl.restart && (POS_W < ws) && (prev_value > sample);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.advance) begin
			valid_q <= keep;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			value_q <= prev_value;
		end
	end

endmodule

`default_nettype wire

[design/swm_head_sel.sv]
// swm_head_sel: two-level registered search for the oldest live cell
// depends on swm_pkg for the group size; fed by the cell row
`default_nettype none

module swm_head_sel #(
	parameter int N = 64,
	parameter int W = 16
) (
	input  wire logic                 clk,
	input  wire logic                 load_s2,
	input  wire logic [N-1:0]         cell_valid,
	input  wire logic signed [W-1:0]  cell_value [N],
	output logic signed [W-1:0]       head
);
	import swm_pkg::*;

	localparam int NG = (N + GROUP - 1) / GROUP;

	logic signed [W-1:0] grp_val [NG];
	logic [NG-1:0]       grp_any;
	logic signed [W-1:0] grp_val_s2 [NG];
	logic [NG-1:0]       grp_any_s2;

	// oldest live entry wins within each group
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_val[g] = cell_value[g * GROUP];
			grp_any[g] = 1'b0;
			for (int j = 0; j < GROUP; j++) begin
				if ((g * GROUP + j < N) && cell_valid[g * GROUP + j]) begin
					grp_val[g] = cell_value[g * GROUP + j];
					grp_any[g] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			grp_val_s2 <= grp_val;
			grp_any_s2 <= grp_any;
		end
	end

	always_comb begin
		head = grp_val_s2[0];
		for (int g = 0; g < NG; g++) begin
			if (grp_any_s2[g]) begin
				head = grp_val_s2[g];
			end
		end
	end

endmodule

`default_nettype wire

[design/sliding_window_maximum_top.sv]
// sliding_window_maximum_top: running maximum over the last window_size samples
// depends on swm_pkg, swm_if, swm_cell and swm_head_sel
//
// usage:
// samples carries one signed sample and a restart flag per request; restart
// empties the window before that sample is taken. results carries window_max,
// one request per sample once window_size samples have arrived since reset or
// the last restart, none before. cfg writes window_size (0 acts as 1, values
// above WINDOW_MAX act as WINDOW_MAX); it is always ready. it is to be written
// only while the block is idle, a rule on the user that the block does not enforce.
// a row of WINDOW_MAX cells shifts by one position per sample, so a cell's
// index is its sample's age; a cell is dropped when it leaves the window or
// a newer sample is greater or equal.
// throughput: one sample per cycle while results takes its requests. a result
// passes through the cell row, the registered oldest-cell search over groups
// of eight cells and the output register before it is shown.
// reset clears the cells' valid flags, the sample count and all pipeline
// flags and sets window_size to 3. when results stalls, the output register,
// the search stage and the cell row each hold one result, then samples.ready
// drops until results takes its request.
`default_nettype none

module sliding_window_maximum_top #(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	swm_sample_if.sink   samples,
	swm_result_if.source results,
	swm_cfg_if.sink      cfg
);
	import swm_pkg::*;

	localparam int SEEN_W = $clog2(WINDOW_MAX + 1);
	localparam int WS_W   = (SEEN_W > CFG_W) ? SEEN_W : CFG_W;
	localparam logic [WS_W-1:0]   WMAX_WS   = WS_W'(WINDOW_MAX);
	localparam logic [SEEN_W-1:0] WMAX_SEEN = SEEN_W'(WINDOW_MAX);

	logic [CFG_W-1:0]  window_size_q;
	logic [SEEN_W-1:0] seen_q;
	logic [SEEN_W-1:0] seen_next;
	logic [WS_W-1:0]   ws_raw;
	logic [WS_W-1:0]   ws_eff;
	logic              accept;
	logic              emit;
	swm_ctrl_t         ctrl;

	logic                         v_s1;
	logic                         v_s2;
	logic                         out_v_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;
	logic                         out_free;
	logic                         load_out;
	logic                         s2_free;
	logic                         load_s2;

	logic [WINDOW_MAX-1:0]         cell_valid;
	logic signed [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] head;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_RESET;
		end else if (cfg.valid && cfg.ready) begin
			window_size_q <= cfg.data;
		end
	end

	always_comb begin
		ws_raw = WS_W'(window_size_q);
		if (ws_raw == '0) begin
			ws_eff = WS_W'(1);
		end else if (ws_raw > WMAX_WS) begin
			ws_eff = WMAX_WS;
		end else begin
			ws_eff = ws_raw;
		end
	end

	// handshake and pipeline control
	assign out_free      = !out_v_q || results.ready;
	assign load_out      = v_s2 && out_free;
	assign s2_free       = !v_s2 || load_out;
	assign load_s2       = v_s1 && s2_free;
	assign samples.ready = !v_s1 || s2_free;
	assign accept        = samples.valid && samples.ready;

	assign ctrl.advance = accept;
	assign ctrl.restart = samples.restart;

	always_comb begin
		if (samples.restart) begin
			seen_next = SEEN_W'(1);
		end else if (seen_q == WMAX_SEEN) begin
			seen_next = seen_q;
		end else begin
			seen_next = seen_q + SEEN_W'(1);
		end
	end

	assign emit = WS_W'(seen_next) >= ws_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept) begin
				seen_q <= seen_next;
				v_s1   <= emit;
			end else if (load_s2) begin
				v_s1 <= 1'b0;
			end
			if (load_s2) begin
				v_s2 <= 1'b1;
			end else if (load_out) begin
				v_s2 <= 1'b0;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= head;
		end
	end

	assign results.valid      = out_v_q;
	assign results.window_max = out_data_q;

	// cell row, newest sample at cell 0
	for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
		if (k == 0) begin : g_first
			swm_cell #(.W(SAMPLE_BITS), .WS_W(WS_W), .POS(k)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.sample     (samples.sample),
				.ws         (ws_eff),
				.prev_value (samples.sample),
				.prev_valid (1'b1),
				.value_q    (cell_value[k]),
				.valid_q    (cell_valid[k])
			);
		end else begin : g_rest
			swm_cell #(.W(SAMPLE_BITS), .WS_W(WS_W), .POS(k)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.sample     (samples.sample),
				.ws         (ws_eff),
				.prev_value (cell_value[k-1]),
				.prev_valid (cell_valid[k-1]),
				.value_q    (cell_value[k]),
				.valid_q    (cell_valid[k])
			);
		end
	end

	swm_head_sel #(.N(WINDOW_MAX), .W(SAMPLE_BITS)) u_head_sel (
		.clk        (clk),
		.load_s2    (load_s2),
		.cell_valid (cell_valid),
		.cell_value (cell_value),
		.head       (head)
	);

`ifndef NO_ASSERTIONS
	a_ready_when_s1_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> samples.ready)
		else $error("sample channel stalled with no pending result");

	a_newest_live: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> cell_valid[0])
		else $error("pending result without a live newest cell");

	a_restart_single: assert property (@(posedge clk) disable iff (!arst_n)
		accept && samples.restart |=> $countones(cell_valid) == 1)
		else $error("restart left older cells live");

	a_out_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(v_s2))
		else $error("result shown without a search stage request");
`endif

endmodule

`default_nettype wire

[tb/tb_sliding_window_maximum_top.sv]
// tb_sliding_window_maximum_top: self-checking bench for the sliding window maximum block
// streams signed samples under random idling on both channels and checks every window_max
// against an internal monotonic-queue predictor; depends on swm_pkg, swm_if and the top level
`default_nettype none

module tb_sliding_window_maximum_top;
	timeunit 1ns;
	timeprecision 1ps;

	import swm_pkg::*;

	localparam int WINDOW_MAX = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int RESET_CYCLES = 12;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int N_PHASES = 14;
	localparam int PRESSURE_PHASE = 3;
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 16'sh8000;
	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 16'sh7fff;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] value;
		logic restart;
	} sample_req_t;

	logic clk = 1'b0;
	logic arst_n;

	swm_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
	swm_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_ch ();
	swm_cfg_if cfg_ch ();

	sliding_window_maximum_top #(
		.WINDOW_MAX(WINDOW_MAX),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(sample_ch),
		.results(result_ch),
		.cfg(cfg_ch)
	);

	always #2 clk = ~clk;

	// predictor state
	logic signed [SAMPLE_BITS-1:0] run_val [WINDOW_MAX];
	int run_age [WINDOW_MAX];
	int run_len = 0;
	int seen_count = 0;
	logic [CFG_W-1:0] window_reg = WINDOW_RESET;

	sample_req_t pending_q [$];
	logic signed [SAMPLE_BITS-1:0] expected_max_q [$];

	int fail_count = 0;
	int cycle_count = 0;
	bit sample_taken = 0;
	int tx_gap = 0;
	int rx_gap = 0;
	int stall_left = 0;
	bit tx_busy_mode = 0;
	bit rx_busy_mode = 0;

	int phase_cfg [N_PHASES] = '{127, 1, 64, 2, 65, 5, 17, 0, 3, 33, 64, 8, 100, 4};
	int phase_len [N_PHASES] = '{120, 80, 120, 100, 120, 80, 100, 80, 80, 120, 120, 80, 100, 80};

	function automatic int clamp_window(input int w);
		if (w == 0)
			return 1;
		if (w > WINDOW_MAX)
			return WINDOW_MAX;
		return w;
	endfunction

	function automatic void slide_window_max(input logic signed [SAMPLE_BITS-1:0] s,
			input logic rst, output bit produced, output logic signed [SAMPLE_BITS-1:0] peak);
		int ws;
		int n;
		int drop;
		int i;
		ws = clamp_window(int'(window_reg));
		if (rst) begin
			run_len = 0;
			seen_count = 0;
		end
		n = run_len;
		for (i = 0; i < n; i++)
			if (run_age[i] < WINDOW_MAX)
				run_age[i]++;
		drop = 0;
		while (drop < n && run_age[drop] >= ws)
			drop++;
		if (drop > 0) begin
			for (i = 0; i + drop < n; i++) begin
				run_val[i] = run_val[i + drop];
				run_age[i] = run_age[i + drop];
			end
			n -= drop;
		end
		while (n > 0 && run_val[n - 1] <= s)
			n--;
		if (n < WINDOW_MAX) begin
			run_val[n] = s;
			run_age[n] = 0;
			n++;
		end else begin
			run_val[WINDOW_MAX - 1] = s;
			run_age[WINDOW_MAX - 1] = 0;
		end
		run_len = n;
		if (seen_count < WINDOW_MAX)
			seen_count++;
		produced = (seen_count >= ws);
		peak = run_val[0];
	endfunction

	function automatic int pick_gap(input bit busy);
		int r;
		if (!busy)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] next_sample(
			input logic signed [SAMPLE_BITS-1:0] prev);
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			return 16'($urandom);
		if (pick < 8)
			return 16'(int'($urandom_range(0, 6)) - 3);
		if (pick == 8) begin
			case ($urandom_range(0, 3))
				0: return S_MIN;
				1: return S_MAX;
				2: return -16'sd1;
				default: return 16'sd0;
			endcase
		end
		return prev + 16'(int'($urandom_range(0, 8)) - 4);
	endfunction

	task automatic push_item(input logic signed [SAMPLE_BITS-1:0] v, input logic rs);
		sample_req_t req;
		req.value = v;
		req.restart = rs;
		pending_q.insert(pending_q.size(), req);
	endtask

	task automatic queue_random_run(input int count, input int eff_ws);
		int k;
		logic signed [SAMPLE_BITS-1:0] v;
		logic rs;
		v = '0;
		for (k = 0; k < count; k++) begin
			v = next_sample(v);
			rs = ($urandom_range(0, 4 * eff_ws + 8) == 0);
			push_item(v, rs);
		end
	endtask

	task automatic settle_idle();
		while (pending_q.size() != 0 || sample_ch.valid)
			@(posedge clk);
		while (expected_max_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [CFG_W-1:0] w);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= w;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	always @(negedge clk) begin : drive_samples
		sample_req_t req;
		if (!sample_ch.valid || sample_taken) begin
			sample_taken = 0;
			if (tx_gap > 0) begin
				sample_ch.valid <= 1'b0;
				tx_gap--;
			end else if (pending_q.size() != 0) begin
				req = pending_q[0];
				pending_q.delete(0);
				sample_ch.sample <= req.value;
				sample_ch.restart <= req.restart;
				sample_ch.valid <= 1'b1;
				tx_gap = pick_gap(tx_busy_mode);
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : drive_ready
		if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else if (rx_gap > 0) begin
			result_ch.ready <= 1'b0;
			rx_gap--;
		end else begin
			result_ch.ready <= 1'b1;
			rx_gap = pick_gap(rx_busy_mode);
		end
	end

	always @(posedge clk) begin : observe
		bit produced;
		logic signed [SAMPLE_BITS-1:0] peak;
		logic signed [SAMPLE_BITS-1:0] want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_max_q.size() == 0) begin
					$error("window_max: expected none, got %0d", result_ch.window_max);
					fail_count++;
				end else begin
					want = expected_max_q[0];
					expected_max_q.delete(0);
					if (result_ch.window_max !== want) begin
						$error("window_max: expected %0d, got %0d", want, result_ch.window_max);
						fail_count++;
					end
				end
			end
			if (sample_ch.valid && sample_ch.ready) begin
				slide_window_max(sample_ch.sample, sample_ch.restart, produced, peak);
				if (produced)
					expected_max_q.insert(expected_max_q.size(), peak);
				sample_taken = 1;
			end
			if (cfg_ch.valid && cfg_ch.ready)
				window_reg = cfg_ch.data;
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_sliding_window_maximum_top: errors");
		$finish;
	end

	initial begin : stimulus
		int p;
		int eff;
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		sample_ch.restart = 1'b0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset window of three: extremes, ties, restart, falling and rising runs
		tx_busy_mode = 1;
		rx_busy_mode = 1;
		push_item(S_MAX, 1'b0);
		push_item(S_MIN, 1'b0);
		push_item(S_MIN, 1'b0);
		push_item(16'sd0, 1'b0);
		push_item(-16'sd1, 1'b0);
		push_item(-16'sd1, 1'b0);
		push_item(-16'sd1, 1'b0);
		push_item(16'sd5, 1'b1);
		push_item(16'sd5, 1'b0);
		push_item(16'sd5, 1'b0);
		push_item(16'sd4, 1'b0);
		push_item(16'sd3, 1'b0);
		push_item(16'sd2, 1'b0);
		push_item(16'sd1, 1'b0);
		push_item(S_MIN, 1'b1);
		push_item(16'sd1, 1'b0);
		push_item(16'sd2, 1'b0);
		push_item(16'sd3, 1'b0);
		settle_idle();

		// zero window acts as one
		write_window(7'd0);
		push_item(S_MAX, 1'b0);
		push_item(S_MIN, 1'b1);
		push_item(-16'sd1, 1'b0);
		push_item(16'sd0, 1'b0);
		push_item(16'sd7, 1'b0);

		for (p = 0; p < N_PHASES; p++) begin
			settle_idle();
			eff = clamp_window(phase_cfg[p]);
			tx_busy_mode = (p % 3 != 0);
			rx_busy_mode = (p % 3 != 1);
			if (p == PRESSURE_PHASE) begin
				tx_busy_mode = 0;
				stall_left = HOLD_OFF_CYCLES;
			end
			write_window(CFG_W'(phase_cfg[p]));
			queue_random_run(phase_len[p], eff);
		end
		settle_idle();

		if (fail_count == 0)
			$display("tb_sliding_window_maximum_top: clean");
		else
			$display("tb_sliding_window_maximum_top: errors");
		$finish;
	end

endmodule

`default_nettype wire

[sliding_window_maximum_top.f]
design/swm_pkg.sv
design/swm_if.sv
design/swm_cell.sv
design/swm_head_sel.sv
design/sliding_window_maximum_top.sv
tb/tb_sliding_window_maximum_top.sv
